// File: src/srec_pkg.sv
// Shared types, character codes and helper functions for the S-record parser.
// Depends on nothing; srec_parse, the parser core and the testbench import this package.
package srec_pkg;

	// Parser position within a record.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_S,
		PH_COUNT,
		PH_ADDR,
		PH_DATA,
		PH_CS
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;
	localparam logic [1:0] KIND_END = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_BAD_CHAR = 2'd0;
	localparam logic [1:0] ERR_BAD_COUNT = 2'd1;
	localparam logic [1:0] ERR_CHECKSUM = 2'd2;
	localparam logic [1:0] ERR_EARLY_END = 2'd3;

	// Input operations.
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END = 1'b1;

	// Characters and constants of the record format.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_FOUR = 8'h34;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] SUM_OK = 8'hFF;
	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	// One result beat.
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] record_type;
		logic [31:0] byte_address;
		logic [7:0] data_byte;
		logic [1:0] error_code;
		logic [15:0] line_number;
	} res_t;

	// Address length in bytes for each record type digit.
	function automatic logic [2:0] addr_len(input logic [3:0] rtype);
		logic [2:0] len;
		case (rtype)
			4'd2, 4'd6, 4'd8: len = 3'd3;
			4'd3, 4'd7: len = 3'd4;
			default: len = 3'd2;
		endcase
		return len;
	endfunction

	// Uppercase hex digit value; bit 4 is set when the character is a hex digit.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, c[3:0]};
		end else if (c >= CH_A && c <= CH_F) begin
			r = {1'b1, c[3:0] + 4'd9};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

endpackage

// File: src/srec_in_if.sv
// Input channel of the S-record parser: one character or end mark per beat.
// Depends on nothing.
interface srec_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [7:0] char_in;

	modport source (output valid, output op, output char_in, input ready);
	modport sink (input valid, input op, input char_in, output ready);
endinterface

// File: src/srec_out_if.sv
// Result channel of the S-record parser: one result per beat.
// Depends on nothing.
interface srec_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [3:0] record_type;
	logic [31:0] byte_address;
	logic [7:0] data_byte;
	logic [1:0] error_code;
	logic [15:0] line_number;

	modport source (output valid, output kind, output record_type, output byte_address,
		output data_byte, output error_code, output line_number, input ready);
	modport sink (input valid, input kind, input record_type, input byte_address,
		input data_byte, input error_code, input line_number, output ready);
endinterface

// File: src/srec_parse.sv
// Record state machine of the S-record parser: holds the record state and
// computes the result of one item. Depends on srec_pkg.
module srec_parse (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic op,
	input logic [7:0] char_in,
	output logic res_valid,
	output srec_pkg::res_t res
);
	import srec_pkg::*;

	phase_t phase_q, phase_d;
	logic halted_q, halted_d;
	logic [3:0] rec_type_q, rec_type_d;
	logic [7:0] byte_count_q, byte_count_d;
	logic [31:0] rec_address_q, rec_address_d;
	logic [7:0] running_sum_q, running_sum_d;
	logic [3:0] high_nibble_q, high_nibble_d;
	logic [3:0] digit_index_q, digit_index_d;
	logic [7:0] data_left_q, data_left_d;
	logic [7:0] data_offset_q, data_offset_d;
	logic [15:0] line_count_q, line_count_d;

	logic [4:0] hex;
	logic is_hex;
	logic [7:0] b;
	logic [2:0] alen;
	logic [3:0] digit_next;
	logic count_short;
	logic addr_done;
	logic [7:0] data_left_init;
	logic [7:0] sum_next;
	logic type_ok;
	logic emits_data;

	// Shared decode of the current character against the record state.
	assign hex = hex_decode(char_in);
	assign is_hex = hex[4];
	assign b = {high_nibble_q, hex[3:0]};
	assign alen = addr_len(rec_type_q);
	assign digit_next = digit_index_q + 4'd1;
	assign count_short = b < ({5'd0, alen} + 8'd1);
	assign addr_done = digit_next >= {alen, 1'b0};
	assign data_left_init = byte_count_q - {5'd0, alen} - 8'd1;
	assign sum_next = running_sum_q + b;
	assign type_ok = (char_in inside {[CH_ZERO:CH_NINE]}) && (char_in != CH_FOUR);
	assign emits_data = (rec_type_q inside {[4'd1:4'd3]});

	// Next-state logic.
	always_comb begin
		phase_d = phase_q;
		halted_d = halted_q;
		rec_type_d = rec_type_q;
		byte_count_d = byte_count_q;
		rec_address_d = rec_address_q;
		running_sum_d = running_sum_q;
		high_nibble_d = high_nibble_q;
		digit_index_d = digit_index_q;
		data_left_d = data_left_q;
		data_offset_d = data_offset_q;
		line_count_d = line_count_q;
		if (step && !halted_q) begin
			if (op == OP_END) begin
				if (phase_q != PH_IDLE) begin
					halted_d = 1'b1;
				end
			end else if (char_in != CH_CR) begin
				case (phase_q)
					PH_IDLE: begin
						if (char_in == CH_LF) begin
							if (line_count_q != LINE_MAX) begin
								line_count_d = line_count_q + 16'd1;
							end
						end else if (char_in == CH_S) begin
							phase_d = PH_S;
						end else begin
							halted_d = 1'b1;
						end
					end
					PH_S: begin
						if (type_ok) begin
							rec_type_d = char_in[3:0];
							byte_count_d = 8'd0;
							rec_address_d = 32'd0;
							running_sum_d = 8'd0;
							high_nibble_d = 4'd0;
							digit_index_d = 4'd0;
							data_left_d = 8'd0;
							data_offset_d = 8'd0;
							phase_d = PH_COUNT;
						end else begin
							halted_d = 1'b1;
						end
					end
					default: begin
						if (!is_hex) begin
							halted_d = 1'b1;
						end else if (!digit_index_q[0]) begin
							high_nibble_d = hex[3:0];
							digit_index_d = digit_next;
						end else begin
							case (phase_q)
								PH_COUNT: begin
									byte_count_d = b;
									running_sum_d = sum_next;
									digit_index_d = 4'd0;
									if (count_short) begin
										halted_d = 1'b1;
									end else begin
										phase_d = PH_ADDR;
									end
								end
								PH_ADDR: begin
									rec_address_d = {rec_address_q[23:0], b};
									running_sum_d = sum_next;
									digit_index_d = digit_next;
									if (addr_done) begin
										digit_index_d = 4'd0;
										data_left_d = data_left_init;
										data_offset_d = 8'd0;
										phase_d = (data_left_init != 8'd0) ? PH_DATA : PH_CS;
									end
								end
								PH_DATA: begin
									running_sum_d = sum_next;
									data_offset_d = data_offset_q + 8'd1;
									data_left_d = data_left_q - 8'd1;
									digit_index_d = 4'd0;
									if (data_left_q == 8'd1) begin
										phase_d = PH_CS;
									end
								end
								default: begin
									digit_index_d = 4'd0;
									if ((running_sum_q ^ b) != SUM_OK) begin
										halted_d = 1'b1;
									end else begin
										phase_d = PH_IDLE;
									end
								end
							endcase
						end
					end
				endcase
			end
		end
	end

	// Result logic.
	always_comb begin
		res_valid = 1'b0;
		res.kind = KIND_ERROR;
		res.record_type = rec_type_q;
		res.byte_address = 32'd0;
		res.data_byte = 8'd0;
		res.error_code = ERR_BAD_CHAR;
		res.line_number = line_count_q;
		if (step && !halted_q) begin
			if (op == OP_END) begin
				res_valid = 1'b1;
				if (phase_q != PH_IDLE) begin
					res.error_code = ERR_EARLY_END;
				end else begin
					res.kind = KIND_END;
				end
			end else if (char_in != CH_CR) begin
				case (phase_q)
					PH_IDLE: begin
						res_valid = (char_in != CH_LF) && (char_in != CH_S);
					end
					PH_S: begin
						res_valid = !type_ok;
					end
					default: begin
						if (!is_hex) begin
							res_valid = 1'b1;
						end else if (digit_index_q[0]) begin
							case (phase_q)
								PH_COUNT: begin
									res_valid = count_short;
									res.error_code = ERR_BAD_COUNT;
								end
								PH_DATA: begin
									res_valid = emits_data;
									res.kind = KIND_DATA;
									res.byte_address = rec_address_q + {24'd0, data_offset_q};
									res.data_byte = b;
								end
								PH_CS: begin
									res_valid = 1'b1;
									if ((running_sum_q ^ b) != SUM_OK) begin
										res.error_code = ERR_CHECKSUM;
									end else begin
										res.kind = KIND_DONE;
										res.byte_address = rec_address_q;
									end
								end
								default: begin
									res_valid = 1'b0;
								end
							endcase
						end
					end
				endcase
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			halted_q <= 1'b0;
			rec_type_q <= 4'd0;
			byte_count_q <= 8'd0;
			rec_address_q <= 32'd0;
			running_sum_q <= 8'd0;
			high_nibble_q <= 4'd0;
			digit_index_q <= 4'd0;
			data_left_q <= 8'd0;
			data_offset_q <= 8'd0;
			line_count_q <= 16'd1;
		end else begin
			phase_q <= phase_d;
			halted_q <= halted_d;
			rec_type_q <= rec_type_d;
			byte_count_q <= byte_count_d;
			rec_address_q <= rec_address_d;
			running_sum_q <= running_sum_d;
			high_nibble_q <= high_nibble_d;
			digit_index_q <= digit_index_d;
			data_left_q <= data_left_d;
			data_offset_q <= data_offset_d;
			line_count_q <= line_count_d;
		end
	end
endmodule

// File: src/srec_record_parser_core.sv
// S-record parser top level: input register, record state machine, result register.
// Flow: a beat accepted into the input register is processed when it advances into the
// state machine, and its result, if any, is then held in the result register for output.
// Throughput: one beat per cycle while the result register is free or being emptied.
// Reset: arst_n clears both pipeline registers and returns the parser to idle, line 1.
// Depends on srec_pkg, srec_in_if, srec_out_if and srec_parse.
module srec_record_parser_core (
	input logic clk,
	input logic arst_n,
	srec_in_if.sink in_ch,
	srec_out_if.source out_ch
);
	import srec_pkg::*;

	logic valid_s1;
	logic op_s1;
	logic [7:0] char_s1;
	logic advance;
	logic res_valid;
	res_t res;
	logic out_valid_q;
	res_t res_q;

	// The held beat moves on when the result register is free or being emptied.
	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1 <= in_ch.op;
			char_s1 <= in_ch.char_in;
		end
	end

	srec_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.op(op_s1),
		.char_in(char_s1),
		.res_valid(res_valid),
		.res(res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = res_q.kind;
	assign out_ch.record_type = res_q.record_type;
	assign out_ch.byte_address = res_q.byte_address;
	assign out_ch.data_byte = res_q.data_byte;
	assign out_ch.error_code = res_q.error_code;
	assign out_ch.line_number = res_q.line_number;
endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for srec_record_parser_core: feeds S-record text and end marks,
// predicts every result beat in parallel and compares it field by field.
// Depends on srec_pkg, srec_in_if, srec_out_if and the parser core under src.
module testbench;
	import srec_pkg::*;

	// One pending input beat with its pacing hints.
	typedef struct packed {
		logic op;
		logic [7:0] ch;
		logic drain;
		logic dense;
	} beat_t;

	logic clk;
	logic arst_n;

	srec_in_if in_ch();
	srec_out_if out_ch();

	srec_record_parser_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Pending characters, predicted results and run bookkeeping.
	beat_t char_feed[$];
	res_t results_due[$];
	logic [7:0] rec_text[$];
	beat_t cur_beat;
	int results_in_flight = 0;
	int beats_taken = 0;
	int beats_total = 0;
	int idle_left = 0;
	int stall_left = 0;
	int mismatches = 0;
	int kind_seen[4] = '{0, 0, 0, 0};
	longint cycle_count = 0;
	longint cycle_limit = 64'd50000000;
	string fault_name = "none";
	wire quiet = (cycle_count[9:8] == 2'd0);

	// Parser state as the predictor tracks it.
	phase_t p_phase = PH_IDLE;
	logic p_halted = 1'b0;
	logic [3:0] p_type = '0;
	logic [7:0] p_count = '0;
	logic [31:0] p_addr = '0;
	logic [7:0] p_sum = '0;
	logic [3:0] p_hi = '0;
	logic [8:0] p_digits = '0;
	logic [7:0] p_left = '0;
	logic [7:0] p_offset = '0;
	logic [15:0] p_line = 16'd1;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Address bytes that a record type carries.
	function automatic int addr_bytes(input int rtype);
		if (rtype == 2 || rtype == 6 || rtype == 8) return 3;
		if (rtype == 3 || rtype == 7) return 4;
		return 2;
	endfunction

	function automatic bit is_hex(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_F);
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c <= CH_NINE) return 4'(c - CH_ZERO);
		return 4'(c - CH_A + 8'd10);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'(CH_ZERO + v);
		return 8'(CH_A + v - 4'd10);
	endfunction

	// Result beat stamped with the current record type and line.
	function automatic res_t pack_res(input logic [1:0] kind, input logic [31:0] addr,
		input logic [7:0] data, input logic [1:0] code);
		res_t r;
		r.kind = kind;
		r.record_type = p_type;
		r.byte_address = addr;
		r.data_byte = data;
		r.error_code = code;
		r.line_number = p_line;
		return r;
	endfunction

	// Advances the predicted parser by one beat; hit says whether a result follows.
	task automatic parse_char(input logic op, input logic [7:0] c, output bit hit,
		output res_t r);
		logic [7:0] b;
		int alen;
		hit = 1'b0;
		r = '0;
		if (p_halted) begin
			hit = 1'b0;
		end else if (op == OP_END) begin
			hit = 1'b1;
			if (p_phase != PH_IDLE) begin
				p_halted = 1'b1;
				r = pack_res(KIND_ERROR, '0, '0, ERR_EARLY_END);
			end else begin
				r = pack_res(KIND_END, '0, '0, ERR_BAD_CHAR);
			end
		end else if (c == CH_CR) begin
			hit = 1'b0;
		end else if (p_phase == PH_IDLE) begin
			if (c == CH_LF) begin
				if (p_line != LINE_MAX) p_line = p_line + 16'd1;
			end else if (c == CH_S) begin
				p_phase = PH_S;
			end else begin
				hit = 1'b1;
				p_halted = 1'b1;
				r = pack_res(KIND_ERROR, '0, '0, ERR_BAD_CHAR);
			end
		end else if (p_phase == PH_S) begin
			if (c < CH_ZERO || c > CH_NINE || c == CH_FOUR) begin
				hit = 1'b1;
				p_halted = 1'b1;
				r = pack_res(KIND_ERROR, '0, '0, ERR_BAD_CHAR);
			end else begin
				p_type = 4'(c - CH_ZERO);
				p_count = '0;
				p_addr = '0;
				p_sum = '0;
				p_hi = '0;
				p_digits = '0;
				p_left = '0;
				p_offset = '0;
				p_phase = PH_COUNT;
			end
		end else if (!is_hex(c)) begin
			hit = 1'b1;
			p_halted = 1'b1;
			r = pack_res(KIND_ERROR, '0, '0, ERR_BAD_CHAR);
		end else if (!p_digits[0]) begin
			// First digit of a byte only latches the high nibble.
			p_hi = hex_nibble(c);
			p_digits = p_digits + 9'd1;
		end else begin
			p_digits = p_digits + 9'd1;
			b = {p_hi, hex_nibble(c)};
			alen = addr_bytes(p_type);
			case (p_phase)
				PH_COUNT: begin
					p_count = b;
					p_sum = p_sum + b;
					if (int'(b) < alen + 1) begin
						hit = 1'b1;
						p_halted = 1'b1;
						r = pack_res(KIND_ERROR, '0, '0, ERR_BAD_COUNT);
					end else begin
						p_digits = '0;
						p_phase = PH_ADDR;
					end
				end
				PH_ADDR: begin
					p_addr = {p_addr[23:0], b};
					p_sum = p_sum + b;
					if (int'(p_digits) >= 2 * alen) begin
						p_digits = '0;
						p_left = 8'(int'(p_count) - alen - 1);
						p_offset = '0;
						p_phase = (p_left != 8'd0) ? PH_DATA : PH_CS;
					end
				end
				PH_DATA: begin
					// Only S1 to S3 emit their payload; other types just sum it.
					if (p_type >= 4'd1 && p_type <= 4'd3) begin
						hit = 1'b1;
						r = pack_res(KIND_DATA, p_addr + {24'd0, p_offset}, b, ERR_BAD_CHAR);
					end
					p_sum = p_sum + b;
					p_offset = p_offset + 8'd1;
					p_left = p_left - 8'd1;
					p_digits = '0;
					if (p_left == 8'd0) p_phase = PH_CS;
				end
				default: begin
					p_digits = '0;
					hit = 1'b1;
					if ((p_sum ^ b) != SUM_OK) begin
						p_halted = 1'b1;
						r = pack_res(KIND_ERROR, '0, '0, ERR_CHECKSUM);
					end else begin
						p_phase = PH_IDLE;
						r = pack_res(KIND_DONE, p_addr, '0, ERR_BAD_CHAR);
					end
				end
			endcase
		end
	endtask

	// Stimulus construction helpers.
	task automatic push_beat(input logic op, input logic [7:0] c, input bit drain,
		input bit dense);
		beat_t nb;
		nb.op = op;
		nb.ch = c;
		nb.drain = drain;
		nb.dense = dense;
		char_feed.push_back(nb);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] data_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// A stray carriage return may sit anywhere in a record.
	task automatic add_text(input logic [7:0] c);
		if ($urandom_range(0, 49) == 0) rec_text.push_back(CH_CR);
		rec_text.push_back(c);
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_text(hex_char(b[7:4]));
		add_text(hex_char(b[3:0]));
	endtask

	// Builds the text of one record, with a correct or a spoiled checksum.
	task automatic build_record(input int rtype, input int count, input logic [31:0] addr,
		input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] v;
		int alen;
		int i;
		rec_text.delete();
		sum = '0;
		alen = addr_bytes(rtype);
		add_text(CH_S);
		add_text(8'(CH_ZERO + rtype));
		v = 8'(count);
		add_byte(v);
		sum = sum + v;
		for (i = alen - 1; i >= 0; i--) begin
			v = addr[8 * i +: 8];
			add_byte(v);
			sum = sum + v;
		end
		for (i = 0; i < count - alen - 1; i++) begin
			v = data_value();
			add_byte(v);
			sum = sum + v;
		end
		v = ~sum;
		if (bad_sum) v = v ^ 8'($urandom_range(1, 255));
		add_byte(v);
	endtask

	task automatic end_line();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) push_beat(OP_CHAR, CH_CR, 1'b0, 1'b0);
		if (r < 8) push_beat(OP_CHAR, CH_LF, 1'b0, 1'b0);
	endtask

	task automatic send_record(input int rtype, input int count, input logic [31:0] addr,
		input bit drain);
		build_record(rtype, count, addr, 1'b0);
		foreach (rec_text[i]) push_beat(OP_CHAR, rec_text[i], drain && (i == 0), 1'b0);
		end_line();
	endtask

	// Mostly data records, the rest header, count and start records.
	task automatic random_record();
		int t;
		int pick;
		int alen;
		int count;
		logic [31:0] addr;
		pick = $urandom_range(0, 5);
		t = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : ((pick == 0) ? 0 : pick + 4);
		alen = addr_bytes(t);
		if ($urandom_range(0, 19) == 0) count = alen + 1 + $urandom_range(0, 254 - alen);
		else count = alen + 1 + $urandom_range(0, 16);
		if ($urandom_range(0, 6) == 0) addr = 32'hFFFFFFFF - $urandom_range(0, 7);
		else addr = $urandom();
		send_record(t, count, addr, $urandom_range(0, 32) == 0);
		if ($urandom_range(0, 11) == 0) push_beat(OP_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
		if ($urandom_range(0, 19) == 0) push_beat(OP_CHAR, CH_LF, 1'b0, 1'b0);
	endtask

	// A character that no record position accepts.
	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = CH_LF;
			1: c = 8'("a" + $urandom_range(0, 5));
			default: begin
				do c = 8'($urandom_range(0, 255));
				while (is_hex(c) || c == CH_CR);
			end
		endcase
		return c;
	endfunction

	// The one error of the run; the parser stays halted after it.
	task automatic push_fault();
		int t;
		int alen;
		int cut;
		logic [7:0] c;
		do t = $urandom_range(0, 9);
		while (t == 4);
		alen = addr_bytes(t);
		build_record(t, alen + 1 + $urandom_range(0, 6), $urandom(), 1'b0);
		cut = $urandom_range(1, rec_text.size() - 1);
		case ($urandom_range(0, 5))
			0: begin
				fault_name = "junk between records";
				do c = 8'($urandom_range(0, 255));
				while (c == CH_CR || c == CH_LF || c == CH_S);
				push_beat(OP_CHAR, c, 1'b0, 1'b0);
			end
			1: begin
				fault_name = "bad type digit";
				do c = 8'($urandom_range(0, 255));
				while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_CR);
				if ($urandom_range(0, 1) == 0) c = CH_FOUR;
				push_beat(OP_CHAR, CH_S, 1'b0, 1'b0);
				push_beat(OP_CHAR, c, 1'b0, 1'b0);
			end
			2: begin
				fault_name = "byte count too short for the address";
				c = 8'($urandom_range(0, alen));
				push_beat(OP_CHAR, CH_S, 1'b0, 1'b0);
				push_beat(OP_CHAR, 8'(CH_ZERO + t), 1'b0, 1'b0);
				push_beat(OP_CHAR, hex_char(c[7:4]), 1'b0, 1'b0);
				push_beat(OP_CHAR, hex_char(c[3:0]), 1'b0, 1'b0);
			end
			3: begin
				fault_name = "checksum mismatch";
				build_record(t, alen + 1 + $urandom_range(0, 6), $urandom(), 1'b1);
				foreach (rec_text[i]) push_beat(OP_CHAR, rec_text[i], 1'b0, 1'b0);
			end
			4: begin
				fault_name = "bad character inside a record";
				for (int i = 0; i < cut; i++) push_beat(OP_CHAR, rec_text[i], 1'b0, 1'b0);
				push_beat(OP_CHAR, junk_char(), 1'b0, 1'b0);
			end
			default: begin
				fault_name = "end of input inside a record";
				for (int i = 0; i < cut; i++) push_beat(OP_CHAR, rec_text[i], 1'b0, 1'b0);
				push_beat(OP_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
		endcase
	endtask

	// Mismatch reporting and result checks.
	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) flag_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
	endtask

	task automatic check_result();
		res_t want;
		if (results_due.size() == 0) begin
			flag_mismatch($sformatf("result of kind %0d with nothing predicted", out_ch.kind));
		end else begin
			want = results_due.pop_front();
			kind_seen[want.kind]++;
			check_field("kind", 32'(out_ch.kind), 32'(want.kind));
			check_field("record_type", 32'(out_ch.record_type), 32'(want.record_type));
			check_field("byte_address", out_ch.byte_address, want.byte_address);
			check_field("data_byte", 32'(out_ch.data_byte), 32'(want.data_byte));
			check_field("error_code", 32'(out_ch.error_code), 32'(want.error_code));
			check_field("line_number", 32'(out_ch.line_number), 32'(want.line_number));
		end
	endtask

	// Input driver: predicts each accepted beat and presents the next one, at times after a random gap.
	always @(posedge clk) begin : drive
		bit hit;
		res_t r;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.op <= OP_CHAR;
			in_ch.char_in <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				parse_char(in_ch.op, in_ch.char_in, hit, r);
				beats_taken++;
				if (hit) begin
					results_due.push_back(r);
					results_in_flight++;
				end
			end
			if (out_ch.valid && out_ch.ready) results_in_flight--;
			if (!in_ch.valid || in_ch.ready) begin
				if (idle_left != 0) begin
					idle_left--;
					in_ch.valid <= 1'b0;
				end else if (char_feed.size() != 0 &&
					!(char_feed[0].drain && results_in_flight > 0)) begin
					cur_beat = char_feed.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.op <= cur_beat.op;
					in_ch.char_in <= cur_beat.ch;
					if (cur_beat.dense || quiet || $urandom_range(0, 99) >= 30) idle_left = 0;
					else idle_left = pick_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks every accepted result beat and stalls at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) check_result();
			if (stall_left != 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
			end
		end
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("run stopped: no completion within %0d cycles", cycle_limit);
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int mark;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_CHAR;
		in_ch.char_in = '0;
		out_ch.ready = 1'b0;

		// Directed: clean end on line 1, blank lines, then every record type except S4.
		push_beat(OP_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
		push_beat(OP_CHAR, CH_LF, 1'b0, 1'b0);
		push_beat(OP_CHAR, CH_CR, 1'b0, 1'b0);
		push_beat(OP_CHAR, CH_LF, 1'b0, 1'b0);
		send_record(0, 3, 32'h0, 1'b1);
		send_record(1, 5, 32'hFFFF, 1'b0);
		send_record(2, 6, 32'hFFFFFF, 1'b0);
		// The data address wraps past the top of the 32-bit space.
		send_record(3, 8, 32'hFFFFFFFF, 1'b0);
		send_record(5, 6, 32'h0003, 1'b0);
		push_beat(OP_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
		send_record(6, 4, 32'h000123, 1'b0);
		send_record(7, 5, 32'h80000000, 1'b0);
		send_record(8, 4, 32'h00FFFFFF, 1'b0);
		send_record(9, 3, 32'h0000, 1'b0);
		send_record(3, 255, $urandom(), 1'b1);

		// Random records fill out the rest of the run.
		mark = char_feed.size();
		while (char_feed.size() - mark < 800) begin
			random_record();
		end

		// The single error, then beats that the halted parser must swallow.
		push_fault();
		send_record(1, 6, $urandom(), 1'b0);
		repeat (40) begin
			if ($urandom_range(0, 9) < 3) push_beat(OP_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
			else push_beat(OP_CHAR, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end

		beats_total = char_feed.size();
		cycle_limit = longint'(beats_total) * 140 + 20000;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_taken != beats_total) @(negedge clk);
		while (results_due.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);

		$display("covered %0d beats: %0d data bytes, %0d records closed, %0d clean end marks",
			beats_taken, kind_seen[KIND_DATA], kind_seen[KIND_DONE], kind_seen[KIND_END]);
		$display("closing fault: %s, %0d error result, last line %0d",
			fault_name, kind_seen[KIND_ERROR], p_line);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
